>>> src/sfr_pkg.sv
// Shared types, constants and helpers for the stream find-and-replace block.
package sfr_pkg;

   localparam int MAX_PATTERN_BYTES     = 8;
   localparam int MAX_REPLACEMENT_BYTES = 8;
   localparam int RESULT_LIMIT          = 8;

   localparam int BYTE_WIDTH      = 8;
   localparam int LEN_WIDTH       = 4;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int WIN_PTR_WIDTH   = $clog2(MAX_PATTERN_BYTES);
   localparam int REP_PTR_WIDTH   = $clog2(MAX_REPLACEMENT_BYTES);
   localparam int CNT_WIDTH       = $clog2(RESULT_LIMIT + 1);

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PATTERN_BYTES      = 2'd0,
      CSR_PATTERN_LENGTH     = 2'd1,
      CSR_REPLACEMENT_BYTES  = 2'd2,
      CSR_REPLACEMENT_LENGTH = 2'd3
   } csr_index_type;

   // configuration as seen by the datapath, lengths already clamped
   typedef struct packed {
      logic [MAX_PATTERN_BYTES*BYTE_WIDTH-1:0]     pattern;
      logic [LEN_WIDTH-1:0]                        pattern_len;
      logic [MAX_REPLACEMENT_BYTES*BYTE_WIDTH-1:0] replacement;
      logic [LEN_WIDTH-1:0]                        replacement_len;
   } cfg_type;

   // operations of the window compare/shift unit
   typedef enum logic [2:0] {
      WIN_HOLD,
      WIN_LOAD,
      WIN_STEP,
      WIN_DROP_HEAD,
      WIN_DROP_MATCH
   } win_op_type;

   typedef struct packed {
      win_op_type            op;
      logic [BYTE_WIDTH-1:0] load_byte;
   } win_cmd_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] head;
      logic                  pending;
      logic                  hit;
      logic                  complete;
      logic                  empty;
   } win_stat_type;

   // requests to the output stage
   typedef struct packed {
      logic                  emit;
      logic [BYTE_WIDTH-1:0] data;
      logic                  any_match;
      logic                  close;
      logic                  last;
   } out_cmd_type;

   typedef struct packed {
      logic emit_ok;
      logic close_ok;
   } out_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPL,
      ST_FLUSH,
      ST_FINISH
   } state_type;

   // zero reads as one, anything above the maximum reads as the maximum
   function automatic logic [LEN_WIDTH-1:0] clamp_len(input logic [LEN_WIDTH-1:0] value,
                                                      input logic [LEN_WIDTH-1:0] max_value);
      logic [LEN_WIDTH-1:0] result;
      if (value == '0) begin
         result = LEN_WIDTH'(1);
      end else if (value > max_value) begin
         result = max_value;
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

>>> src/sfr_if.sv
// Channel interfaces: input words, result words and configuration writes.
interface sfr_req_if;
   logic                           valid;
   logic                           ready;
   logic [sfr_pkg::BYTE_WIDTH-1:0] in_byte;
   logic                           in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface sfr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sfr_pkg::BYTE_WIDTH-1:0] out_byte;
   logic                           run_last;
   logic                           stream_end;
   logic                           any_match;

   modport source (output valid, output out_byte, output run_last, output stream_end,
                   output any_match, input ready);
   modport sink (input valid, input out_byte, input run_last, input stream_end,
                 input any_match, output ready);
endinterface

interface sfr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [sfr_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [sfr_pkg::CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/stream_find_and_replace.sv
// Top level of the streaming find-and-replace block.
//
// Usage: bytes of a stream enter on req_chan (in_byte, in_last marks the final
// byte); rewritten bytes leave on rsp_chan. Every leftmost non-overlapping
// occurrence of the pattern is replaced by the replacement bytes. csr_chan
// writes pattern_bytes (0), pattern_length (1), replacement_bytes (2) and
// replacement_length (3); it is always ready. It is to be written between steps
// by the user; the block itself does not enforce this. Each result word carries
// run_last on the final word caused by an input byte, stream_end on the final
// word of a stream, and any_match once a replacement has been made in the
// current stream. At most 8 result words per input byte. One input byte is
// handled at a time, set by the single compare/shift unit on the window buffer
// doing one action (compare, emit, rescan or replacement byte) per cycle while
// rsp_chan does not stall. A byte is accepted, then gets its actions, a check
// that the buffer is drained, a flush of held bytes at stream end, and a
// closing step. The last word of a byte moves from the lookahead into the
// result register when the byte is closed. Reset clears the window, the match
// flag and the output stage and restores a single zero byte pattern and
// replacement. When rsp_chan stalls, the sequencer holds at its next emit or
// close.
module stream_find_and_replace (
   input  logic       clock,
   input  logic       reset,
   sfr_req_if.sink    req_chan,
   sfr_rsp_if.source  rsp_chan,
   sfr_csr_if.sink    csr_chan
);

   sfr_pkg::cfg_type      cfg;
   sfr_pkg::win_cmd_type  win_cmd;
   sfr_pkg::win_stat_type win_stat;
   sfr_pkg::out_cmd_type  out_cmd;
   sfr_pkg::out_stat_type out_stat;

   sfr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   sfr_window u_window (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .cmd   (win_cmd),
      .stat  (win_stat)
   );

   sfr_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .win_stat (win_stat),
      .out_stat (out_stat),
      .win_cmd  (win_cmd),
      .out_cmd  (out_cmd)
   );

   sfr_out u_out (
      .clock    (clock),
      .reset    (reset),
      .cmd      (out_cmd),
      .stat     (out_stat),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> src/sfr_csr.sv
// Configuration registers with length clamping.
module sfr_csr (
   input  logic             clock,
   input  logic             reset,
   sfr_csr_if.sink          csr_chan,
   output sfr_pkg::cfg_type cfg
);

   logic [sfr_pkg::MAX_PATTERN_BYTES*sfr_pkg::BYTE_WIDTH-1:0]     pattern_ff;
   logic [sfr_pkg::LEN_WIDTH-1:0]                                 pattern_len_ff;
   logic [sfr_pkg::MAX_REPLACEMENT_BYTES*sfr_pkg::BYTE_WIDTH-1:0] replacement_ff;
   logic [sfr_pkg::LEN_WIDTH-1:0]                                 replacement_len_ff;

   // always take writes
   assign csr_chan.ready = 1'b1;

   // store register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff         <= '0;
         pattern_len_ff     <= sfr_pkg::LEN_WIDTH'(1);
         replacement_ff     <= '0;
         replacement_len_ff <= sfr_pkg::LEN_WIDTH'(1);
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            sfr_pkg::CSR_PATTERN_BYTES: begin
               pattern_ff <= csr_chan.data[sfr_pkg::MAX_PATTERN_BYTES*sfr_pkg::BYTE_WIDTH-1:0];
            end
            sfr_pkg::CSR_PATTERN_LENGTH: begin
               pattern_len_ff <= csr_chan.data[sfr_pkg::LEN_WIDTH-1:0];
            end
            sfr_pkg::CSR_REPLACEMENT_BYTES: begin
               replacement_ff <=
                  csr_chan.data[sfr_pkg::MAX_REPLACEMENT_BYTES*sfr_pkg::BYTE_WIDTH-1:0];
            end
            sfr_pkg::CSR_REPLACEMENT_LENGTH: begin
               replacement_len_ff <= csr_chan.data[sfr_pkg::LEN_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // present clamped lengths
   always_comb begin
      cfg.pattern         = pattern_ff;
      cfg.pattern_len     = sfr_pkg::clamp_len(pattern_len_ff,
                                               sfr_pkg::LEN_WIDTH'(sfr_pkg::MAX_PATTERN_BYTES));
      cfg.replacement     = replacement_ff;
      cfg.replacement_len = sfr_pkg::clamp_len(replacement_len_ff,
                                               sfr_pkg::LEN_WIDTH'(sfr_pkg::MAX_REPLACEMENT_BYTES));
   end

endmodule

>>> src/sfr_window.sv
// Match window: byte buffer, pattern compare and shared shift unit.
module sfr_window (
   input  logic                  clock,
   input  logic                  reset,
   input  sfr_pkg::cfg_type      cfg,
   input  sfr_pkg::win_cmd_type  cmd,
   output sfr_pkg::win_stat_type stat
);

   // buffer holds matched bytes (below wc) followed by bytes still to scan
   logic [sfr_pkg::BYTE_WIDTH-1:0]    buf_ff [sfr_pkg::MAX_PATTERN_BYTES];
   logic [sfr_pkg::BYTE_WIDTH-1:0]    buf_in [sfr_pkg::MAX_PATTERN_BYTES];
   logic [sfr_pkg::LEN_WIDTH-1:0]     n_ff, n_in;
   logic [sfr_pkg::LEN_WIDTH-1:0]     wc_ff, wc_in;

   logic [sfr_pkg::WIN_PTR_WIDTH-1:0] wptr;
   logic [sfr_pkg::BYTE_WIDTH-1:0]    pat_byte;
   logic [sfr_pkg::LEN_WIDTH-1:0]     shift_amt;
   logic [sfr_pkg::LEN_WIDTH-1:0]     src_idx [sfr_pkg::MAX_PATTERN_BYTES];

   // compare the scan byte against the pattern
   always_comb begin
      wptr          = wc_ff[sfr_pkg::WIN_PTR_WIDTH-1:0];
      pat_byte      = cfg.pattern[{wptr, 3'b000} +: sfr_pkg::BYTE_WIDTH];
      stat.head     = buf_ff[0];
      stat.pending  = wc_ff < n_ff;
      stat.hit      = (wc_ff < n_ff) && (wc_ff < cfg.pattern_len) && (buf_ff[wptr] == pat_byte);
      stat.complete = (wc_ff + sfr_pkg::LEN_WIDTH'(1)) == cfg.pattern_len;
      stat.empty    = n_ff == '0;
   end

   // shift unit and window update
   always_comb begin
      shift_amt = (cmd.op == sfr_pkg::WIN_DROP_MATCH) ? cfg.pattern_len : sfr_pkg::LEN_WIDTH'(1);
      buf_in    = buf_ff;
      n_in      = n_ff;
      wc_in     = wc_ff;
      for (int i = 0; i < sfr_pkg::MAX_PATTERN_BYTES; i++) begin
         src_idx[i] = sfr_pkg::LEN_WIDTH'(i) + shift_amt;
      end
      case (cmd.op)
         sfr_pkg::WIN_LOAD: begin
            buf_in[n_ff[sfr_pkg::WIN_PTR_WIDTH-1:0]] = cmd.load_byte;
            n_in = n_ff + sfr_pkg::LEN_WIDTH'(1);
         end
         sfr_pkg::WIN_STEP: begin
            wc_in = wc_ff + sfr_pkg::LEN_WIDTH'(1);
         end
         sfr_pkg::WIN_DROP_HEAD, sfr_pkg::WIN_DROP_MATCH: begin
            for (int i = 0; i < sfr_pkg::MAX_PATTERN_BYTES; i++) begin
               if (src_idx[i] < sfr_pkg::LEN_WIDTH'(sfr_pkg::MAX_PATTERN_BYTES)) begin
                  buf_in[i] = buf_ff[src_idx[i][sfr_pkg::WIN_PTR_WIDTH-1:0]];
               end
            end
            n_in  = n_ff - shift_amt;
            wc_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff  <= '0;
         wc_ff <= '0;
      end else begin
         n_ff  <= n_in;
         wc_ff <= wc_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) wc_ff <= n_ff)
      else $error("window match count beyond buffered bytes");
   assert property (@(posedge clock) disable iff (reset)
                    n_ff <= sfr_pkg::LEN_WIDTH'(sfr_pkg::MAX_PATTERN_BYTES))
      else $error("window buffer overflow");
   assert property (@(posedge clock) disable iff (reset)
                    cmd.op == sfr_pkg::WIN_DROP_MATCH |-> cfg.pattern_len <= n_ff)
      else $error("match drop larger than buffer");

endmodule

>>> src/sfr_seq.sv
// Sequencer: one window action per cycle unless stalled; issues output words.
module sfr_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  sfr_pkg::cfg_type      cfg,
   sfr_req_if.sink               req_chan,
   input  sfr_pkg::win_stat_type win_stat,
   input  sfr_pkg::out_stat_type out_stat,
   output sfr_pkg::win_cmd_type  win_cmd,
   output sfr_pkg::out_cmd_type  out_cmd
);

   sfr_pkg::state_type state_ff, state_in;
   logic                             last_ff, last_in;
   logic                             match_seen_ff, match_seen_in;
   logic [sfr_pkg::REP_PTR_WIDTH-1:0] ri_ff, ri_in;
   logic [sfr_pkg::LEN_WIDTH-1:0]    rlen_m1;

   assign rlen_m1 = cfg.replacement_len - sfr_pkg::LEN_WIDTH'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sfr_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = sfr_pkg::ST_SCAN;
            end
         end
         sfr_pkg::ST_SCAN: begin
            if (!win_stat.pending) begin
               state_in = last_ff ? sfr_pkg::ST_FLUSH : sfr_pkg::ST_FINISH;
            end else if (win_stat.hit && win_stat.complete) begin
               state_in = sfr_pkg::ST_REPL;
            end
         end
         sfr_pkg::ST_REPL: begin
            if (out_stat.emit_ok && (ri_ff == rlen_m1[sfr_pkg::REP_PTR_WIDTH-1:0])) begin
               state_in = sfr_pkg::ST_SCAN;
            end
         end
         sfr_pkg::ST_FLUSH: begin
            if (win_stat.empty) begin
               state_in = sfr_pkg::ST_FINISH;
            end
         end
         sfr_pkg::ST_FINISH: begin
            if (out_stat.close_ok) begin
               state_in = sfr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sfr_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_chan.ready    = 1'b0;
      win_cmd.op        = sfr_pkg::WIN_HOLD;
      win_cmd.load_byte = req_chan.in_byte;
      out_cmd.emit      = 1'b0;
      out_cmd.data      = win_stat.head;
      out_cmd.any_match = match_seen_ff;
      out_cmd.close     = 1'b0;
      out_cmd.last      = last_ff;
      last_in           = last_ff;
      match_seen_in     = match_seen_ff;
      ri_in             = ri_ff;
      case (state_ff)
         sfr_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               win_cmd.op = sfr_pkg::WIN_LOAD;
               last_in    = req_chan.in_last;
            end
         end
         sfr_pkg::ST_SCAN: begin
            if (win_stat.pending) begin
               if (win_stat.hit) begin
                  if (win_stat.complete) begin
                     // whole pattern held: drop it and start the replacement
                     win_cmd.op    = sfr_pkg::WIN_DROP_MATCH;
                     match_seen_in = 1'b1;
                     ri_in         = '0;
                  end else begin
                     win_cmd.op = sfr_pkg::WIN_STEP;
                  end
               end else begin
                  // mismatch: emit the head and rescan the rest
                  out_cmd.emit = 1'b1;
                  if (out_stat.emit_ok) begin
                     win_cmd.op = sfr_pkg::WIN_DROP_HEAD;
                  end
               end
            end
         end
         sfr_pkg::ST_REPL: begin
            out_cmd.emit = 1'b1;
            out_cmd.data = cfg.replacement[{ri_ff, 3'b000} +: sfr_pkg::BYTE_WIDTH];
            if (out_stat.emit_ok) begin
               ri_in = ri_ff + sfr_pkg::REP_PTR_WIDTH'(1);
            end
         end
         sfr_pkg::ST_FLUSH: begin
            if (!win_stat.empty) begin
               out_cmd.emit = 1'b1;
               if (out_stat.emit_ok) begin
                  win_cmd.op = sfr_pkg::WIN_DROP_HEAD;
               end
            end
         end
         sfr_pkg::ST_FINISH: begin
            out_cmd.close = 1'b1;
            if (out_stat.close_ok && last_ff) begin
               match_seen_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sfr_pkg::ST_IDLE;
         last_ff       <= 1'b0;
         match_seen_ff <= 1'b0;
         ri_ff         <= '0;
      end else begin
         state_ff      <= state_in;
         last_ff       <= last_in;
         match_seen_ff <= match_seen_in;
         ri_ff         <= ri_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
                    state_ff == sfr_pkg::ST_REPL |-> match_seen_ff)
      else $error("replacement emitted without a recorded match");
   assert property (@(posedge clock) disable iff (reset)
                    state_ff == sfr_pkg::ST_FINISH && out_stat.close_ok && last_ff
                    |=> !match_seen_ff && state_ff == sfr_pkg::ST_IDLE)
      else $error("stream end did not clear the match flag");

endmodule

>>> src/sfr_out.sv
// Output stage: one-word lookahead to mark the last word of a step, plus result register.
module sfr_out (
   input  logic                  clock,
   input  logic                  reset,
   input  sfr_pkg::out_cmd_type  cmd,
   output sfr_pkg::out_stat_type stat,
   sfr_rsp_if.source             rsp_chan
);

   logic                           hold_v_ff, hold_v_in;
   logic [sfr_pkg::BYTE_WIDTH-1:0] hold_byte_ff, hold_byte_in;
   logic                           hold_am_ff, hold_am_in;

   logic                           out_v_ff, out_v_in;
   logic [sfr_pkg::BYTE_WIDTH-1:0] out_byte_ff, out_byte_in;
   logic                           out_run_last_ff, out_run_last_in;
   logic                           out_end_ff, out_end_in;
   logic                           out_am_ff, out_am_in;

   logic [sfr_pkg::CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                           drop;
   logic                           out_free;

   assign drop          = cnt_ff == sfr_pkg::CNT_WIDTH'(sfr_pkg::RESULT_LIMIT);
   assign out_free      = !out_v_ff || rsp_chan.ready;
   assign stat.emit_ok  = drop || !hold_v_ff || out_free;
   assign stat.close_ok = !hold_v_ff || out_free;

   // move words from the lookahead into the result register
   always_comb begin
      hold_v_in       = hold_v_ff;
      hold_byte_in    = hold_byte_ff;
      hold_am_in      = hold_am_ff;
      out_v_in        = out_v_ff && !rsp_chan.ready;
      out_byte_in     = out_byte_ff;
      out_run_last_in = out_run_last_ff;
      out_end_in      = out_end_ff;
      out_am_in       = out_am_ff;
      cnt_in          = cnt_ff;
      if (cmd.emit && stat.emit_ok && !drop) begin
         if (hold_v_ff) begin
            out_v_in        = 1'b1;
            out_byte_in     = hold_byte_ff;
            out_run_last_in = 1'b0;
            out_end_in      = 1'b0;
            out_am_in       = hold_am_ff;
         end
         hold_v_in    = 1'b1;
         hold_byte_in = cmd.data;
         hold_am_in   = cmd.any_match;
         cnt_in       = cnt_ff + sfr_pkg::CNT_WIDTH'(1);
      end else if (cmd.close && stat.close_ok) begin
         // close the step: the held word is its final result
         if (hold_v_ff) begin
            out_v_in        = 1'b1;
            out_byte_in     = hold_byte_ff;
            out_run_last_in = 1'b1;
            out_end_in      = cmd.last;
            out_am_in       = hold_am_ff;
         end
         hold_v_in = 1'b0;
         cnt_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      hold_byte_ff    <= hold_byte_in;
      hold_am_ff      <= hold_am_in;
      out_byte_ff     <= out_byte_in;
      out_run_last_ff <= out_run_last_in;
      out_end_ff      <= out_end_in;
      out_am_ff       <= out_am_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign rsp_chan.valid      = out_v_ff;
   assign rsp_chan.out_byte   = out_byte_ff;
   assign rsp_chan.run_last   = out_run_last_ff;
   assign rsp_chan.stream_end = out_end_ff;
   assign rsp_chan.any_match  = out_am_ff;

   assert property (@(posedge clock) disable iff (reset) hold_v_ff |-> cnt_ff != '0)
      else $error("held word without a result count");

endmodule

>>> dv/tb_stream_find_and_replace.sv
// Testbench for the stream find-and-replace block: directed and random streams, scoreboard check.

// one result word as it leaves the block
typedef struct packed {
   logic [7:0] out_byte;
   logic       run_last;
   logic       stream_end;
   logic       any_match;
} rewrite_word_type;

// Tracks the rewrite of the stream and checks every result word against it.
class sfr_scoreboard;
   logic [63:0]      pattern_reg;
   logic [3:0]       pattern_len_reg;
   logic [63:0]      replacement_reg;
   logic [3:0]       replacement_len_reg;
   logic [7:0]       window [sfr_pkg::MAX_PATTERN_BYTES];
   int unsigned      window_count;
   bit               match_seen;
   rewrite_word_type step_words[$];
   rewrite_word_type expected_words[$];
   int               errors;

   function new();
      pattern_reg         = '0;
      pattern_len_reg     = 4'd1;
      replacement_reg     = '0;
      replacement_len_reg = 4'd1;
      window_count        = 0;
      match_seen          = 1'b0;
      errors              = 0;
      foreach (window[i]) window[i] = '0;
   endfunction

   function int pending();
      return expected_words.size();
   endfunction

   function void write_reg(sfr_pkg::csr_index_type idx, logic [63:0] value);
      case (idx)
         sfr_pkg::CSR_PATTERN_BYTES:      pattern_reg = value;
         sfr_pkg::CSR_PATTERN_LENGTH:     pattern_len_reg = value[3:0];
         sfr_pkg::CSR_REPLACEMENT_BYTES:  replacement_reg = value;
         sfr_pkg::CSR_REPLACEMENT_LENGTH: replacement_len_reg = value[3:0];
         default: ;
      endcase
   endfunction

   // append one word of the current step, drop anything past the limit
   function void emit_byte(logic [7:0] b);
      rewrite_word_type w;
      if (step_words.size() < sfr_pkg::RESULT_LIMIT) begin
         w.out_byte   = b;
         w.run_last   = 1'b0;
         w.stream_end = 1'b0;
         w.any_match  = match_seen;
         step_words.push_back(w);
      end
   endfunction

   // advance the window by one accepted byte and queue the words it causes
   function void note_byte(logic [7:0] in_byte, logic in_last);
      int unsigned plen;
      int unsigned rlen;
      int          last_idx;
      logic [7:0]  rescan[$];
      logic [7:0]  c;
      plen = (pattern_len_reg == 0) ? 1 :
             (pattern_len_reg > sfr_pkg::MAX_PATTERN_BYTES) ? sfr_pkg::MAX_PATTERN_BYTES :
             pattern_len_reg;
      rlen = (replacement_len_reg == 0) ? 1 :
             (replacement_len_reg > sfr_pkg::MAX_REPLACEMENT_BYTES) ?
             sfr_pkg::MAX_REPLACEMENT_BYTES : replacement_len_reg;
      step_words.delete();
      if (window_count > sfr_pkg::MAX_PATTERN_BYTES) window_count = sfr_pkg::MAX_PATTERN_BYTES;
      rescan.push_back(in_byte);
      while (rescan.size() != 0) begin
         c = rescan.pop_front();
         if (window_count < plen && c == pattern_reg[8*window_count +: 8]) begin
            window[window_count] = c;
            window_count++;
            if (window_count >= plen) begin
               match_seen = 1'b1;
               for (int i = 0; i < rlen; i++) emit_byte(replacement_reg[8*i +: 8]);
               window_count = 0;
            end
         end else begin
            // mismatch: release the head, put the rest of the window back in front
            if (window_count > 0) begin
               rescan.push_front(c);
               for (int i = window_count; i > 1; i--) rescan.push_front(window[i-1]);
               c = window[0];
               window_count = 0;
            end
            emit_byte(c);
         end
      end
      // flush a partial match at stream end
      if (in_last) begin
         for (int i = 0; i < window_count; i++) emit_byte(window[i]);
         window_count = 0;
      end
      if (step_words.size() > 0) begin
         last_idx = step_words.size() - 1;
         step_words[last_idx].run_last   = 1'b1;
         step_words[last_idx].stream_end = in_last;
      end
      if (in_last) match_seen = 1'b0;
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
   endfunction

   task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
   endtask

   task check_word(rewrite_word_type got);
      rewrite_word_type exp;
      if (expected_words.size() == 0) begin
         report($sformatf("word %h with nothing expected", got.out_byte));
      end else begin
         exp = expected_words.pop_front();
         if (got.out_byte !== exp.out_byte)
            report($sformatf("out_byte %h, expected %h", got.out_byte, exp.out_byte));
         if (got.run_last !== exp.run_last)
            report($sformatf("run_last %b, expected %b (byte %h)", got.run_last,
                             exp.run_last, exp.out_byte));
         if (got.stream_end !== exp.stream_end)
            report($sformatf("stream_end %b, expected %b (byte %h)", got.stream_end,
                             exp.stream_end, exp.out_byte));
         if (got.any_match !== exp.any_match)
            report($sformatf("any_match %b, expected %b (byte %h)", got.any_match,
                             exp.any_match, exp.out_byte));
      end
   endtask
endclass

module tb_stream_find_and_replace;

   localparam int RANDOM_ITEMS   = 260;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 4000;

   logic clock;
   logic reset;

   sfr_req_if req_bus ();
   sfr_rsp_if rsp_bus ();
   sfr_csr_if csr_bus ();

   stream_find_and_replace dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   sfr_scoreboard sb;
   int            idle_cycles = 0;
   int            burst_left  = 0;

   // clock, period 4
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // observe all three channels; configuration and input before results
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            sb.write_reg(sfr_pkg::csr_index_type'(csr_bus.index), csr_bus.data);
         if (req_bus.valid && req_bus.ready)
            sb.note_byte(req_bus.in_byte, req_bus.in_last);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_word('{rsp_bus.out_byte, rsp_bus.run_last, rsp_bus.stream_end,
                            rsp_bus.any_match});
      end
      if ((csr_bus.valid && csr_bus.ready) || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
   end

   // receiver: switch between always ready, coin flips and long stalls
   int  ready_mode      = 0;
   int  ready_mode_left = 0;
   int  ready_hold_left = 0;
   bit  ready_level     = 1'b1;
   always @(posedge clock) begin
      if (ready_mode_left == 0) begin
         ready_mode      = $urandom_range(0, 2);
         ready_mode_left = $urandom_range(20, 100);
      end
      ready_mode_left--;
      case (ready_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= 1'($urandom_range(0, 1));
         default: begin
            if (ready_hold_left == 0) begin
               ready_level     = !ready_level;
               ready_hold_left = ready_level ? $urandom_range(1, 8) : $urandom_range(1, 12);
            end
            ready_hold_left--;
            rsp_bus.ready <= ready_level;
         end
      endcase
   end

   // end the run when nothing moves for too long
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("end of test: mismatches");
      $finish;
   end

   // send one word, in bursts with random gaps between them
   task automatic send_word(input logic [7:0] data, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= data;
      req_bus.in_last <= last;
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
   endtask

   task automatic write_csr(input sfr_pkg::csr_index_type idx, input logic [63:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic program_regs(input logic [63:0] pattern, input logic [63:0] plen_word,
                               input logic [63:0] repl, input logic [63:0] rlen_word);
      write_csr(sfr_pkg::CSR_PATTERN_BYTES, pattern);
      write_csr(sfr_pkg::CSR_PATTERN_LENGTH, plen_word);
      write_csr(sfr_pkg::CSR_REPLACEMENT_BYTES, repl);
      write_csr(sfr_pkg::CSR_REPLACEMENT_LENGTH, rlen_word);
      csr_bus.valid <= 1'b0;
   endtask

   // hold the sender until every expected word is back and the block is quiet
   task automatic drain();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [63:0] pattern;
      logic [63:0] plen_word;
      logic [63:0] repl;
      logic [63:0] rlen_word;
      logic [7:0]  sym [3];
      logic [7:0]  stream_q[$];
      logic [7:0]  noise;
      int          cur_plen;
      int          random_sent;
      int          phase_items;
      int          phase_sent;
      int          stream_len;
      int          pick;
      int          n;
      bit          keep_open;

      sb = new();
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.in_byte = '0;
      req_bus.in_last = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = '0;
      csr_bus.data    = '0;
      rsp_bus.ready   = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset registers: single zero byte pattern and replacement
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b1);

      // all-ones pattern, length above maximum, replacement length zero
      drain();
      program_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_000F, 64'h0,
                   64'hFFFF_FFFF_FFFF_FFF0);
      repeat (8) send_word(8'hFF, 1'b0);
      repeat (7) send_word(8'hFF, 1'b0);

      // shrink the pattern with seven bytes held: rescan overflows the word limit
      drain();
      program_regs(64'h0000_0000_0000_00FF, 64'd1, 64'h0123_4567_89AB_CDEF, 64'd8);
      send_word(8'hFF, 1'b1);

      // backtracking on a partial match and a flush at stream end
      drain();
      program_regs(64'h6261, 64'd2, 64'h5A5958, 64'd3);
      send_word(8'h61, 1'b0);
      send_word(8'h61, 1'b0);
      send_word(8'h62, 1'b0);
      send_word(8'h61, 1'b1);

      // random phases, each with a fresh configuration
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         pick      = $urandom_range(0, 9);
         plen_word = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'h0;
         plen_word[3:0] = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd15 : 4'($urandom_range(1, 8));
         cur_plen  = (plen_word[3:0] == 0) ? 1 : (plen_word[3:0] > 8) ? 8 : plen_word[3:0];
         foreach (sym[k]) sym[k] = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 3) == 0) begin
            pattern = {$urandom, $urandom};
         end else begin
            for (int k = 0; k < 8; k++) pattern[8*k +: 8] = sym[$urandom_range(0, 2)];
         end
         repl      = {$urandom, $urandom};
         pick      = $urandom_range(0, 9);
         rlen_word = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'h0;
         rlen_word[3:0] = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd15 : 4'($urandom_range(1, 8));
         drain();
         program_regs(pattern, plen_word, repl, rlen_word);

         phase_items = $urandom_range(16, 40);
         phase_sent  = 0;
         while (phase_sent < phase_items) begin
            // build a stream mostly from whole and partial pattern copies
            stream_len = $urandom_range(1, 24);
            stream_q.delete();
            while (stream_q.size() < stream_len) begin
               pick = $urandom_range(0, 9);
               if (pick <= 3) begin
                  for (int k = 0; k < cur_plen; k++) stream_q.push_back(pattern[8*k +: 8]);
               end else if (pick <= 5) begin
                  n = $urandom_range(1, cur_plen);
                  for (int k = 0; k < n; k++) stream_q.push_back(pattern[8*k +: 8]);
               end else begin
                  pick = $urandom_range(0, 9);
                  if (pick < 5)
                     noise = sym[$urandom_range(0, 2)];
                  else if (pick < 8)
                     noise = pattern[8*$urandom_range(0, cur_plen - 1) +: 8];
                  else
                     noise = 8'($urandom_range(0, 255));
                  stream_q.push_back(noise);
               end
            end
            // leave the last stream of a phase open now and then
            keep_open = (phase_sent + stream_q.size() >= phase_items) &&
                        ($urandom_range(0, 2) == 0);
            foreach (stream_q[i])
               send_word(stream_q[i], (i == stream_q.size() - 1) && !keep_open);
            phase_sent  += stream_q.size();
            random_sent += stream_q.size();
            // now and then, hold off until the block has returned everything
            if ($urandom_range(0, 5) == 0) begin
               req_bus.valid <= 1'b0;
               burst_left = 0;
               do @(posedge clock); while (sb.pending() != 0);
            end
         end
      end
      send_word(8'($urandom_range(0, 255)), 1'b1);

      // wait for the last words, then let the block settle
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
